// ===== rtl/biq_pkg.sv =====
// ----------------------------------------------------------------------------
// biq_pkg
// Shared constants and types of the biquad filter: widths, register indexes,
// datapath command and status bundles.
// ----------------------------------------------------------------------------
package biq_pkg;

  localparam int unsigned SAMPLE_BITS_DEF    = 16;
  localparam int unsigned COEF_FRAC_BITS_DEF = 14;

  localparam int unsigned COEF_W    = 18;
  localparam int unsigned STATE_W   = 40;
  localparam int unsigned NUM_COEFS = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [COEF_W-1:0] COEF_B0_RST = COEF_W'(16384);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    MUL_B0_X = 3'd0,
    MUL_B1_X = 3'd1,
    MUL_A1_Y = 3'd2,
    MUL_B2_X = 3'd3,
    MUL_A2_Y = 3'd4
  } mul_sel_e;

  typedef enum logic [1:0] {
    SUM_PROD_PLUS_D2 = 2'd0,
    SUM_MINUS_PROD   = 2'd1,
    SUM_PROD         = 2'd2
  } sum_op_e;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     y_en;
    logic     sum_en;
    sum_op_e  sum_op;
    logic     d1_en;
    logic     d2_out_en;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/biq_if.sv =====
// ----------------------------------------------------------------------------
// biq_if
// Valid/ready channels of the biquad filter, one for input items and one for
// result items.
// ----------------------------------------------------------------------------
interface biq_in_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          frame_end_in;

  modport source (output valid, output sample_in, output frame_end_in, input ready);
  modport sink   (input valid, input sample_in, input frame_end_in, output ready);
endinterface

interface biq_out_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          frame_end_out;

  modport source (output valid, output sample_out, output frame_end_out, input ready);
  modport sink   (input valid, input sample_out, input frame_end_out, output ready);
endinterface

// ===== rtl/biq_ctrl.sv =====
// ----------------------------------------------------------------------------
// biq_ctrl
// Sequencer of the biquad filter: steps one item through the shared
// multiplier and adders of the datapath.
// ----------------------------------------------------------------------------
module biq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  biq_pkg::status_t sts_i,
  output biq_pkg::cmd_t    cmd_o
);
  import biq_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MB0  = 8'b0000_0010,
    ST_ACC  = 8'b0000_0100,
    ST_OUT  = 8'b0000_1000,
    ST_T1   = 8'b0001_0000,
    ST_T2   = 8'b0010_0000,
    ST_T3   = 8'b0100_0000,
    ST_T4   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MB0;
        end
      end
      ST_MB0: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_B0_X;
        state_d       = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.y_en    = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_B1_X;
        state_d       = ST_T1;
      end
      ST_T1: begin
        cmd_o.sum_en  = 1'b1;
        cmd_o.sum_op  = SUM_PROD_PLUS_D2;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_A1_Y;
        state_d       = ST_T2;
      end
      ST_T2: begin
        cmd_o.sum_en  = 1'b1;
        cmd_o.sum_op  = SUM_MINUS_PROD;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_B2_X;
        state_d       = ST_T3;
      end
      ST_T3: begin
        cmd_o.d1_en   = 1'b1;
        cmd_o.sum_en  = 1'b1;
        cmd_o.sum_op  = SUM_PROD;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_A2_Y;
        state_d       = ST_T4;
      end
      ST_T4: begin
        // wait here while the previous result is still held
        if (!sts_i.out_busy) begin
          cmd_o.d2_out_en = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/biq_datapath.sv =====
// ----------------------------------------------------------------------------
// biq_datapath
// Coefficient registers, shared multiplier, accumulators, delay state and
// output register of the biquad filter.
// ----------------------------------------------------------------------------
module biq_datapath #(
  parameter int unsigned SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [biq_pkg::COEF_W-1:0]        cfg_data_i,
  input  biq_pkg::cmd_t                     cmd_i,
  output biq_pkg::status_t                  sts_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in_i,
  input  logic                              frame_end_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]     sample_out_o,
  output logic                              frame_end_out_o
);
  import biq_pkg::*;

  localparam int unsigned PROD_W = COEF_W + SAMPLE_BITS;
  localparam int unsigned SUM_W  = ((PROD_W > STATE_W) ? PROD_W : STATE_W) + 2;
  localparam int unsigned RND_W  = STATE_W + SAMPLE_BITS + 1;

  localparam logic signed [RND_W-1:0] RoundHalf = RND_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [STATE_W-1:0] StateMax = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] StateMin = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SampleMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SampleMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-STATE_W:0] top;
    top = v[SUM_W-1:STATE_W-1];
    if ((&top) || !(|top)) begin
      return v[STATE_W-1:0];
    end else if (v[SUM_W-1]) begin
      return StateMin;
    end else begin
      return StateMax;
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [RND_W-1:0] v
  );
    logic [RND_W-SAMPLE_BITS:0] top;
    top = v[RND_W-1:SAMPLE_BITS-1];
    if ((&top) || !(|top)) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[RND_W-1]) begin
      return SampleMin;
    end else begin
      return SampleMax;
    end
  endfunction

  logic signed [COEF_W-1:0]      b0_q, b1_q, b2_q, a1_q, a2_q;
  logic signed [SAMPLE_BITS-1:0] x_q, y_q, y_d;
  logic                          fe_q;
  logic signed [COEF_W-1:0]      mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic signed [STATE_W-1:0]     acc_q, acc_d;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [STATE_W-1:0]     d1_q, d2_q, d2_d;
  logic signed [RND_W-1:0]       rnd, shf;
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic                          out_fe_q;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= COEF_B0_RST;
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_B0:  b0_q <= cfg_data_i;
        REG_B1:  b1_q <= cfg_data_i;
        REG_B2:  b2_q <= cfg_data_i;
        REG_A1:  a1_q <= cfg_data_i;
        REG_A2:  a2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_B0_X: begin mul_a = b0_q; mul_b = x_q; end
      MUL_B1_X: begin mul_a = b1_q; mul_b = x_q; end
      MUL_A1_Y: begin mul_a = a1_q; mul_b = y_q; end
      MUL_B2_X: begin mul_a = b2_q; mul_b = x_q; end
      MUL_A2_Y: begin mul_a = a2_q; mul_b = y_q; end
      default:  begin mul_a = b0_q; mul_b = x_q; end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign acc_d  = sat_state(SUM_W'(prod_q) + SUM_W'(d1_q));
  assign rnd    = RND_W'(acc_q) + RoundHalf;
  assign shf    = rnd >>> COEF_FRAC_BITS;
  assign y_d    = sat_sample(shf);
  assign d2_d   = sat_state(sum_q - SUM_W'(prod_q));

  always_comb begin
    unique case (cmd_i.sum_op)
      SUM_PROD_PLUS_D2: sum_d = SUM_W'(prod_q) + SUM_W'(d2_q);
      SUM_MINUS_PROD:   sum_d = sum_q - SUM_W'(prod_q);
      SUM_PROD:         sum_d = SUM_W'(prod_q);
      default:          sum_d = sum_q;
    endcase
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q  <= sample_in_i;
      fe_q <= frame_end_in_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
    end
    if (cmd_i.y_en) begin
      y_q <= y_d;
    end
    if (cmd_i.sum_en) begin
      sum_q <= sum_d;
    end
    if (cmd_i.d2_out_en) begin
      out_sample_q <= y_q;
      out_fe_q     <= fe_q;
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
    end else begin
      if (cmd_i.d1_en) begin
        d1_q <= sat_state(sum_q);
      end
      if (cmd_i.d2_out_en) begin
        d2_q <= d2_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.d2_out_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_sample_q;
  assign frame_end_out_o = out_fe_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.d2_out_en |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten while held");

  a_valid_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.d2_out_en))
    else $error("result valid without a finished item");

  a_acc_fresh_prod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_en |-> $past(cmd_i.mul_en && (cmd_i.mul_sel == MUL_B0_X)))
    else $error("accumulate without b0 product");
`endif

endmodule

// ===== rtl/biquad_iir_filter_core.sv =====
// ----------------------------------------------------------------------------
// biquad_iir_filter_core
// Second-order IIR section, transposed direct form II, fixed point, with
// one shared multiplier sequenced by a small state machine.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    sample_in, frame_end_in
//   out_o    out  valid/ready    sample_out, frame_end_out
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// an item is accepted in ST_IDLE, then steps through ST_MB0, ST_ACC, ST_OUT and ST_T1 to ST_T4
// a new item is accepted only once the previous one has left the sequencer
// a finished item waits in the output register; a new item may enter meanwhile
// a stalled output holds the sequencer at its last step
// reset clears the delay state and loads the default coefficients
// ----------------------------------------------------------------------------
module biquad_iir_filter_core #(
  parameter int unsigned SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  biq_in_if.sink                        in_i,
  biq_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [biq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [biq_pkg::COEF_W-1:0]    cfg_data_i
);
  import biq_pkg::*;

  cmd_t    cmd;
  status_t sts;

  biq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  biq_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sample_in_i     (in_i.sample_in),
    .frame_end_in_i  (in_i.frame_end_in),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .sample_out_o    (out_o.sample_out),
    .frame_end_out_o (out_o.frame_end_out)
  );

endmodule
